[hw/rtl/psewh_pkg.sv]
// Shared types and constants for the power step event window hold block.
// Holds the controller to datapath command and status structs; no dependencies.
package psewh_pkg;

	// Field widths fixed by the record format
	localparam int TIME_W  = 34;
	localparam int POWER_W = 24;

	// Default window depth and threshold reset value
	localparam int                 DEF_WINDOW_DEPTH = 10;
	localparam logic [POWER_W-1:0] THRESH_RESET     = 24'd5000;

	// Source of an emitted result
	typedef enum logic [1:0] {
		SRC_WIN,
		SRC_EVT,
		SRC_SMP
	} src_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic win_wr;       // write accepted sample into window at index
		logic win_append;   // shift window, append sample, keep oldest time
		logic smp_from_in;  // keep accepted sample time for a later result
		logic held_load;    // load held level
		logic evt_wr;       // write accepted sample into event buffer at index
		logic emit;         // load one result into the output register
		src_t src;
		logic raw;
		logic last;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;     // output register can take a result this cycle
		logic step;         // incoming sample jumps beyond the threshold
	} stat_t;

endpackage

[hw/rtl/psewh_dp.sv]
// Datapath: sample window, event buffer, held level, threshold and output register.
// Depends on psewh_pkg; driven by psewh_ctrl through cmd_t.
module psewh_dp #(
	parameter int WINDOW_DEPTH = psewh_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psewh_pkg::cmd_t                     cmd,
	input  logic [$clog2(WINDOW_DEPTH)-1:0]     wr_idx,
	input  logic [psewh_pkg::TIME_W-1:0]        sample_time,
	input  logic [psewh_pkg::POWER_W-1:0]       sample_power,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [psewh_pkg::POWER_W-1:0]       cfg_data,
	input  logic                                out_stall,
	output psewh_pkg::stat_t                    stat,
	output logic                                out_valid,
	output logic [psewh_pkg::TIME_W-1:0]        out_time,
	output logic [psewh_pkg::POWER_W-1:0]       out_power,
	output logic                                is_raw,
	output logic                                last
);

	localparam int TW = psewh_pkg::TIME_W;
	localparam int PW = psewh_pkg::POWER_W;

	logic [TW-1:0] win_time_q  [WINDOW_DEPTH];
	logic [PW-1:0] win_power_q [WINDOW_DEPTH];
	logic [TW-1:0] evt_time_q  [WINDOW_DEPTH];
	logic [PW-1:0] evt_power_q [WINDOW_DEPTH];
	logic [TW-1:0] smp_time_q;
	logic [PW-1:0] held_q;
	logic [PW-1:0] thresh_q;

	logic          out_valid_q;
	logic [TW-1:0] out_time_q;
	logic [PW-1:0] out_power_q;
	logic          out_raw_q;
	logic          out_last_q;

	logic [PW-1:0] newest;
	logic [PW-1:0] diff;
	logic [TW-1:0] res_time;
	logic [PW-1:0] res_power;

	// Compare incoming power with the newest window entry
	always_comb begin
		newest = win_power_q[WINDOW_DEPTH-1];
		diff   = (sample_power > newest) ? (sample_power - newest) : (newest - sample_power);
		stat.step     = diff > thresh_q;
		stat.out_free = !out_valid_q || !out_stall;
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= psewh_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// Held level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.held_load) begin
			held_q <= (wr_idx == '0) ? sample_power : win_power_q[0];
		end
	end

	// Window: indexed fill, shift with append, shift out on emission
	always_ff @(posedge clk) begin
		if (cmd.win_wr) begin
			win_time_q[wr_idx]  <= sample_time;
			win_power_q[wr_idx] <= sample_power;
		end else if (cmd.win_append) begin
			for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
				win_time_q[i]  <= win_time_q[i+1];
				win_power_q[i] <= win_power_q[i+1];
			end
			win_time_q[WINDOW_DEPTH-1]  <= sample_time;
			win_power_q[WINDOW_DEPTH-1] <= sample_power;
		end else if (cmd.emit && cmd.src == psewh_pkg::SRC_WIN) begin
			for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
				win_time_q[i]  <= win_time_q[i+1];
				win_power_q[i] <= win_power_q[i+1];
			end
		end
	end

	// Event buffer: indexed capture, shift out on emission
	always_ff @(posedge clk) begin
		if (cmd.evt_wr) begin
			evt_time_q[wr_idx]  <= sample_time;
			evt_power_q[wr_idx] <= sample_power;
		end else if (cmd.emit && cmd.src == psewh_pkg::SRC_EVT) begin
			for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
				evt_time_q[i]  <= evt_time_q[i+1];
				evt_power_q[i] <= evt_power_q[i+1];
			end
		end
	end

	// Hold the single timestamp emitted with the held level
	always_ff @(posedge clk) begin
		if (cmd.smp_from_in) begin
			smp_time_q <= sample_time;
		end else if (cmd.win_append) begin
			smp_time_q <= win_time_q[0];
		end
	end

	// Select the result for this beat
	always_comb begin
		case (cmd.src)
			psewh_pkg::SRC_WIN: begin
				res_time  = win_time_q[0];
				res_power = cmd.raw ? win_power_q[0] : held_q;
			end
			psewh_pkg::SRC_EVT: begin
				res_time  = evt_time_q[0];
				res_power = evt_power_q[0];
			end
			default: begin
				res_time  = smp_time_q;
				res_power = held_q;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_time_q  <= res_time;
			out_power_q <= res_power;
			out_raw_q   <= cmd.raw;
			out_last_q  <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_time  = out_time_q;
	assign out_power = out_power_q;
	assign is_raw    = out_raw_q;
	assign last      = out_last_q;

endmodule

[hw/rtl/psewh_ctrl.sv]
// Controller: phase, fill position and emission sequencing for the window hold.
// Depends on psewh_pkg; drives psewh_dp through cmd_t and reads stat_t.
module psewh_ctrl #(
	parameter int WINDOW_DEPTH = psewh_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            end_of_stream,
	input  psewh_pkg::stat_t                stat,
	output psewh_pkg::cmd_t                 cmd,
	output logic [$clog2(WINDOW_DEPTH)-1:0] wr_idx,
	output logic                            in_stall
);

	localparam int PSW = $clog2(WINDOW_DEPTH);
	localparam int CW  = $clog2(WINDOW_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_REFILL,
		PH_STEADY,
		PH_CAPTURE
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT_WIN,
		ST_EMIT_EVT,
		ST_EMIT_SMP
	} state_t;

	state_t         state_q;
	phase_t         phase_q;
	logic [PSW-1:0] pos_q;
	logic [CW-1:0]  cnt_q;
	logic           raw_q;
	logic           tail_q;

	logic           acc;
	logic           pos_last;
	logic [CW-1:0]  pos_cnt;

	assign acc      = (state_q == ST_IDLE) && in_valid;
	assign pos_last = pos_q == PSW'(WINDOW_DEPTH - 1);
	assign pos_cnt  = CW'(pos_q) + CW'(1);
	assign wr_idx   = pos_q;
	assign in_stall = state_q != ST_IDLE;

	// Decode commands for the accepted sample and for each emission beat
	always_comb begin
		cmd     = '0;
		cmd.src = psewh_pkg::SRC_WIN;
		if (acc) begin
			unique case (phase_q)
				PH_STEADY: begin
					if (end_of_stream) begin
						cmd.smp_from_in = 1'b1;
					end else if (stat.step) begin
						cmd.evt_wr = 1'b1;
					end else begin
						cmd.win_append = 1'b1;
					end
				end
				PH_CAPTURE: begin
					cmd.evt_wr = 1'b1;
				end
				default: begin
					cmd.win_wr    = 1'b1;
					cmd.held_load = end_of_stream || pos_last;
				end
			endcase
		end else if (state_q != ST_IDLE && stat.out_free) begin
			cmd.emit = 1'b1;
			cmd.raw  = raw_q;
			unique case (state_q)
				ST_EMIT_EVT: begin
					cmd.src  = psewh_pkg::SRC_EVT;
					cmd.last = cnt_q == CW'(1);
				end
				ST_EMIT_SMP: begin
					cmd.src  = psewh_pkg::SRC_SMP;
					cmd.last = 1'b1;
				end
				default: begin
					cmd.src  = psewh_pkg::SRC_WIN;
					cmd.last = (cnt_q == CW'(1)) && !tail_q;
				end
			endcase
		end
	end

	// Hold phase, position and the emission sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_REFILL;
			pos_q   <= '0;
			cnt_q   <= '0;
			raw_q   <= 1'b0;
			tail_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (phase_q)
							PH_STEADY: begin
								if (end_of_stream) begin
									state_q <= ST_EMIT_WIN;
									cnt_q   <= CW'(WINDOW_DEPTH);
									raw_q   <= 1'b0;
									tail_q  <= 1'b1;
									phase_q <= PH_REFILL;
									pos_q   <= '0;
								end else if (stat.step) begin
									state_q <= ST_EMIT_WIN;
									cnt_q   <= CW'(WINDOW_DEPTH);
									raw_q   <= 1'b1;
									tail_q  <= 1'b0;
									phase_q <= PH_CAPTURE;
									pos_q   <= PSW'(1);
								end else begin
									state_q <= ST_EMIT_SMP;
									raw_q   <= 1'b0;
									tail_q  <= 1'b0;
								end
							end
							PH_CAPTURE: begin
								if (end_of_stream || pos_last) begin
									state_q <= ST_EMIT_EVT;
									cnt_q   <= pos_cnt;
									raw_q   <= 1'b1;
									tail_q  <= 1'b0;
									phase_q <= PH_REFILL;
									pos_q   <= '0;
								end else begin
									pos_q <= pos_q + PSW'(1);
								end
							end
							default: begin
								if (end_of_stream) begin
									state_q <= ST_EMIT_WIN;
									cnt_q   <= pos_cnt;
									raw_q   <= 1'b0;
									tail_q  <= 1'b0;
									phase_q <= PH_REFILL;
									pos_q   <= '0;
								end else if (pos_last) begin
									phase_q <= PH_STEADY;
									pos_q   <= '0;
								end else begin
									phase_q <= PH_REFILL;
									pos_q   <= pos_q + PSW'(1);
								end
							end
						endcase
					end
				end
				ST_EMIT_WIN, ST_EMIT_EVT: begin
					if (stat.out_free) begin
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							state_q <= tail_q ? ST_EMIT_SMP : ST_IDLE;
						end
					end
				end
				default: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

[hw/rtl/power_step_event_window_hold.sv]
// Top level of the power step event window hold: controller plus datapath.
// Depends on psewh_pkg, psewh_ctrl and psewh_dp.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    sample_time, sample_power, end_of_stream
//   out      source     out_valid / out_stall  out_time, out_power, is_raw, last
//   cfg      sink       cfg_valid / cfg_ready  cfg_data (step_threshold)
//
// A sample is taken while the controller is idle; its results then pass one by one
// through the output register: at most WINDOW_DEPTH + 1 results on an end of stream
// in steady state, WINDOW_DEPTH on a step. The emission sequencer in the controller
// sends them; in_stall is high while it runs, so no new sample is taken until the
// last result is loaded. A stall on out freezes the sequencer with the beat held.
// Reset clears phase to refill, position and held level to zero, threshold to 5000.
module power_step_event_window_hold #(
	parameter int WINDOW_DEPTH = psewh_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [psewh_pkg::TIME_W-1:0]    sample_time,
	input  logic [psewh_pkg::POWER_W-1:0]   sample_power,
	input  logic                            end_of_stream,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [psewh_pkg::TIME_W-1:0]    out_time,
	output logic [psewh_pkg::POWER_W-1:0]   out_power,
	output logic                            is_raw,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [psewh_pkg::POWER_W-1:0]   cfg_data
);

	psewh_pkg::cmd_t                 cmd;
	psewh_pkg::stat_t                stat;
	logic [$clog2(WINDOW_DEPTH)-1:0] wr_idx;

	// Threshold writes are always accepted; the threshold is registered
	assign cfg_ready = 1'b1;

	psewh_ctrl #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.end_of_stream (end_of_stream),
		.stat          (stat),
		.cmd           (cmd),
		.wr_idx        (wr_idx),
		.in_stall      (in_stall)
	);

	psewh_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.wr_idx       (wr_idx),
		.sample_time  (sample_time),
		.sample_power (sample_power),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_time     (out_time),
		.out_power    (out_power),
		.is_raw       (is_raw),
		.last         (last)
	);

endmodule
